// ----- rtl/core/modular_arithmetic_unit_defines.svh -----
// assertion helpers for the prime-field arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define MAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the following cycle
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MAU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/mau_pkg.sv -----
package mau_pkg;

    localparam int DATA_W = 30;
    localparam int EXP_W  = 64;

    // prime modulus of the field
    localparam logic [DATA_W-1:0] MODULUS = 30'd998244353;
    localparam logic [DATA_W-1:0] MOD_M1  = MODULUS - 30'd1;
    // fermat exponent for the inverse
    localparam logic [EXP_W-1:0]  INV_EXP = {{(EXP_W-DATA_W){1'b0}}, MODULUS} - 64'd2;

    localparam int RED_CNT_W = $clog2(EXP_W);
    localparam int MUL_CNT_W = $clog2(DATA_W);
    localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(EXP_W - 1);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(DATA_W - 1);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4,
        OP_NEG = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_RED_E,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_FIN_MUL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_INV_DIV,
        PH_INV_POW,
        PH_MAIN
    } t_phase;

endpackage

// ----- rtl/core/modular_arithmetic_unit.sv -----
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------------
// request  | i_in_valid / o_in_ready   | i_req_type, i_operand_a, i_operand_b, i_exponent
// result   | o_out_valid / i_out_ready | o_result
//
// one item at a time; each operand is first reduced bit-serially
// power and divide run square-and-multiply on the shared mulmod, up to two
// multiplies per exponent bit
// synchronous active-low reset clears control state only
// a finished result moves to the output register, so the next request can be
// taken while the result waits for its transfer
`include "modular_arithmetic_unit_defines.svh"

module modular_arithmetic_unit import mau_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_req_type,
    input  logic [DATA_W-1:0]       i_operand_a,
    input  logic [DATA_W-1:0]       i_operand_b,
    input  logic signed [EXP_W-1:0] i_exponent,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [DATA_W-1:0]       o_result
);

    t_state r_state;
    t_state n_state;
    t_phase r_phase;

    logic [2:0]        r_op;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [EXP_W-1:0]  r_exp;
    logic [DATA_W:0]   r_eexp;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_base;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] r_out_res;
    logic              r_out_valid;

    logic              in_xfer;
    logic              out_load;

    // serial reducer hookup
    logic              red_start;
    logic [EXP_W-1:0]  red_value;
    logic [DATA_W-1:0] red_mod;
    logic              red_done;
    logic [DATA_W-1:0] red_rem;

    // modular multiplier hookup
    logic              mul_start;
    logic [DATA_W-1:0] mul_x;
    logic [DATA_W-1:0] mul_y;
    logic              mul_done;
    logic [DATA_W-1:0] mul_prod;

    // combinational results for the simple operations
    logic [DATA_W:0]   add_sum;
    logic [DATA_W:0]   sub_wrap;
    logic [DATA_W-1:0] simple_res;
    logic [DATA_W:0]   e_pos;

    mau_reduce u_reduce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (red_start),
        .i_value   (red_value),
        .i_modulus (red_mod),
        .o_done    (red_done),
        .o_rem     (red_rem)
    );

    mau_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_res;

    // add, subtract and negate on reduced operands
    always_comb begin
        add_sum  = {1'b0, r_a} + {1'b0, r_b};
        sub_wrap = {1'b0, r_a} + {1'b0, MODULUS} - {1'b0, r_b};
        unique case (t_op'(r_op))
            OP_ADD: begin
                if (add_sum >= {1'b0, MODULUS}) begin
                    simple_res = DATA_W'(add_sum - {1'b0, MODULUS});
                end else begin
                    simple_res = add_sum[DATA_W-1:0];
                end
            end
            OP_SUB: begin
                if (r_a >= r_b) begin
                    simple_res = r_a - r_b;
                end else begin
                    simple_res = sub_wrap[DATA_W-1:0];
                end
            end
            OP_NEG: begin
                if (r_a == '0) begin
                    simple_res = '0;
                end else begin
                    simple_res = MODULUS - r_a;
                end
            end
            default: simple_res = '0;
        endcase
    end

    // positive exponent for a negative power: (mod-1) + (|n| rem (mod-1))
    assign e_pos = {1'b0, MOD_M1} + {1'b0, red_rem};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_RED_A;
            end
            S_RED_A: begin
                if (red_done) n_state = S_RED_B;
            end
            S_RED_B: begin
                if (red_done) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (t_op'(r_op))
                    OP_MUL: n_state = S_FIN_MUL;
                    OP_DIV: n_state = (r_b == '0) ? S_DONE : S_POW_CHK;
                    OP_POW: n_state = r_exp[EXP_W-1] ? S_RED_E : S_POW_CHK;
                    default: n_state = S_DONE;
                endcase
            end
            S_RED_E: begin
                if (red_done) n_state = S_POW_CHK;
            end
            S_POW_CHK: begin
                if (r_exp == '0) begin
                    unique case (r_phase)
                        PH_INV_DIV: n_state = S_FIN_MUL;
                        PH_INV_POW: n_state = S_POW_CHK;
                        default:    n_state = S_DONE;
                    endcase
                end else if (r_exp[0]) begin
                    n_state = S_POW_MUL;
                end else begin
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL: begin
                if (mul_done) n_state = S_POW_SQR;
            end
            S_POW_SQR: begin
                if (mul_done) n_state = S_POW_CHK;
            end
            S_FIN_MUL: begin
                if (mul_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // unit start strobes and operand selection
    always_comb begin
        red_start = 1'b0;
        red_value = {{(EXP_W-DATA_W){1'b0}}, r_b};
        red_mod   = MODULUS;
        mul_start = 1'b0;
        mul_x     = r_base;
        mul_y     = r_base;
        unique case (r_state)
            S_IDLE: begin
                // operand a goes straight from the port
                red_start = in_xfer;
                red_value = {{(EXP_W-DATA_W){1'b0}}, i_operand_a};
            end
            S_RED_A: begin
                red_start = red_done;
            end
            S_DISPATCH: begin
                if (t_op'(r_op) == OP_MUL) begin
                    mul_start = 1'b1;
                    mul_x     = r_a;
                    mul_y     = r_b;
                end
                if ((t_op'(r_op) == OP_POW) && r_exp[EXP_W-1]) begin
                    red_start = 1'b1;
                    red_value = (~r_exp) + 1'b1;
                    red_mod   = MOD_M1;
                end
            end
            S_POW_CHK: begin
                if (r_exp == '0) begin
                    if (r_phase == PH_INV_DIV) begin
                        mul_start = 1'b1;
                        mul_x     = r_a;
                        mul_y     = r_acc;
                    end
                end else if (r_exp[0]) begin
                    mul_start = 1'b1;
                    mul_x     = r_acc;
                    mul_y     = r_base;
                end else begin
                    mul_start = 1'b1;
                end
            end
            S_POW_MUL: begin
                mul_start = mul_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_res <= r_res;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_op  <= i_req_type;
                    r_b   <= i_operand_b;
                    r_exp <= unsigned'(i_exponent);
                end
            end
            S_RED_A: begin
                if (red_done) r_a <= red_rem;
            end
            S_RED_B: begin
                if (red_done) r_b <= red_rem;
            end
            S_DISPATCH: begin
                r_acc <= DATA_W'(1);
                if (t_op'(r_op) == OP_DIV) begin
                    // inverse of zero counts as one, so a passes through
                    r_res   <= r_a;
                    r_base  <= r_b;
                    r_exp   <= INV_EXP;
                    r_phase <= PH_INV_DIV;
                end else begin
                    r_res <= simple_res;
                    if (t_op'(r_op) == OP_POW) begin
                        r_base  <= r_a;
                        r_phase <= PH_MAIN;
                    end
                end
            end
            S_RED_E: begin
                if (red_done) begin
                    r_eexp <= e_pos;
                    if (r_a == '0) begin
                        r_base  <= DATA_W'(1);
                        r_exp   <= EXP_W'(e_pos);
                        r_phase <= PH_MAIN;
                    end else begin
                        r_base  <= r_a;
                        r_exp   <= INV_EXP;
                        r_phase <= PH_INV_POW;
                    end
                end
            end
            S_POW_CHK: begin
                if (r_exp == '0) begin
                    if (r_phase == PH_INV_POW) begin
                        // inverse done, now raise it to the positive exponent
                        r_base  <= r_acc;
                        r_acc   <= DATA_W'(1);
                        r_exp   <= EXP_W'(r_eexp);
                        r_phase <= PH_MAIN;
                    end
                    r_res <= r_acc;
                end
            end
            S_POW_MUL: begin
                if (mul_done) r_acc <= mul_prod;
            end
            S_POW_SQR: begin
                if (mul_done) begin
                    r_base <= mul_prod;
                    r_exp  <= r_exp >> 1;
                end
            end
            S_FIN_MUL: begin
                if (mul_done) r_res <= mul_prod;
            end
            default: begin
            end
        endcase
    end

    // checks
    `MAU_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)
    `MAU_ASSERT_IMP(a_out_reduced, i_clk, i_rst_n, r_out_valid, r_out_res < MODULUS)
    `MAU_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_xfer, r_state == S_RED_A)

endmodule

// ----- rtl/core/mau_reduce.sv -----
module mau_reduce import mau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [EXP_W-1:0]  i_value,
    input  logic [DATA_W-1:0] i_modulus,
    output logic              o_done,
    output logic [DATA_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [RED_CNT_W-1:0] r_cnt;
    logic [EXP_W-1:0]     r_val;
    logic [DATA_W-1:0]    r_mod;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W:0]      shifted;
    logic [DATA_W-1:0]    n_rem;

    // one bit per cycle, msb first: rem = 2*rem + bit, then one conditional subtract
    always_comb begin
        shifted = {r_rem, r_val[EXP_W-1]};
        if (shifted >= {1'b0, r_mod}) begin
            n_rem = DATA_W'(shifted - {1'b0, r_mod});
        end else begin
            n_rem = shifted[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == RED_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_mod <= i_modulus;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= r_val << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/mau_mulmod.sv -----
module mau_mulmod import mau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_y,
    output logic              o_done,
    output logic [DATA_W-1:0] o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_half;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_x;
    logic [DATA_W-1:0]    r_y;
    logic [DATA_W-1:0]    r_acc;
    logic [DATA_W:0]      dbl;
    logic [DATA_W:0]      sum;
    logic [DATA_W-1:0]    dbl_red;
    logic [DATA_W-1:0]    sum_red;

    // interleaved multiply: for each bit of y, msb first, double then add
    always_comb begin
        dbl = {r_acc, 1'b0};
        sum = {1'b0, r_acc} + {1'b0, r_x};
        if (dbl >= {1'b0, MODULUS}) begin
            dbl_red = DATA_W'(dbl - {1'b0, MODULUS});
        end else begin
            dbl_red = dbl[DATA_W-1:0];
        end
        if (sum >= {1'b0, MODULUS}) begin
            sum_red = DATA_W'(sum - {1'b0, MODULUS});
        end else begin
            sum_red = sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_half <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_half <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_half <= !r_half;
                if (r_half) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy) begin
            if (!r_half) begin
                r_acc <= dbl_red;
            end else begin
                if (r_y[DATA_W-1]) begin
                    r_acc <= sum_red;
                end
                r_y <= r_y << 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- sim/tb_modular_arithmetic_unit.sv -----
`timescale 1ns / 100ps

module tb_modular_arithmetic_unit;
    import mau_pkg::*;

    localparam longint unsigned P   = 998244353;
    localparam longint unsigned PM1 = P - 1;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [2:0]              i_req_type;
    logic [DATA_W-1:0]       i_operand_a;
    logic [DATA_W-1:0]       i_operand_b;
    logic signed [EXP_W-1:0] i_exponent;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [DATA_W-1:0]       o_result;

    modular_arithmetic_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_exponent  (i_exponent),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    // queue of residues still owed by the unit, oldest first
    logic [DATA_W-1:0] residue_q[$];
    int  mismatch_cnt;
    int  orphan_cnt;
    bit  rx_idle_en;     // random receiver stalls enabled
    bit  tx_idle_en;     // random sender gaps enabled
    int  rx_hold_cycles; // long receiver hold-off requested

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // field helpers
    function automatic longint unsigned fmul(longint unsigned x, longint unsigned y);
        return (x * y) % P;
    endfunction

    // extended euclid inverse times a, with the loop's own end-case behavior
    function automatic longint unsigned fdiv(longint unsigned a, longint unsigned b);
        longint cur, prv, hi, lo, q, t, r, prod;
        cur = 1;
        prv = 0;
        hi  = longint'(P);
        lo  = longint'(b);
        while (lo != 0) begin
            q   = hi / lo;
            t   = prv - q * cur;
            r   = hi % lo;
            prv = cur;
            cur = t;
            hi  = lo;
            lo  = r;
        end
        if (cur % longint'(P) == 0) cur = prv;
        prod = (longint'(a) * cur) % longint'(P);
        if (prod < 0) prod += longint'(P);
        return longint'(prod);
    endfunction

    function automatic longint unsigned fpow_u(longint unsigned base, longint unsigned e);
        longint unsigned acc;
        acc = 1;
        while (e != 0) begin
            if (e[0]) acc = fmul(acc, base);
            base = fmul(base, base);
            e = e >> 1;
        end
        return acc;
    endfunction

    // negative exponents go through the inverse of the base
    function automatic longint unsigned fpow(longint unsigned base, logic [63:0] ebits);
        longint unsigned mag;
        if (ebits[63]) begin
            mag = ~ebits + 64'd1;
            return fpow_u(fdiv(1, base), PM1 + (mag % PM1));
        end
        return fpow_u(base, ebits);
    endfunction

    function automatic logic [DATA_W-1:0] field_result(logic [2:0] op, logic [DATA_W-1:0] ra,
                                                      logic [DATA_W-1:0] rb,
                                                      logic [63:0] ex);
        longint unsigned a, b, r;
        a = longint'(ra) % P;
        b = longint'(rb) % P;
        case (op)
            OP_ADD: r = (a + b) % P;
            OP_SUB: r = (a >= b) ? a - b : a + P - b;
            OP_MUL: r = fmul(a, b);
            OP_DIV: r = fdiv(a, b);
            OP_POW: r = fpow(a, ex);
            OP_NEG: r = (a == 0) ? 0 : P - a;
            default: r = 0;
        endcase
        return r[DATA_W-1:0];
    endfunction

    // one request transfer; the residue is queued when the transfer happens
    task automatic send_req(logic [2:0] op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                            logic [63:0] ex);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_req_type  = op;
        i_operand_a = a;
        i_operand_b = b;
        i_exponent  = ex;
        do @(posedge i_clk); while (!o_in_ready);
        residue_q.push_back(field_result(op, a, b, ex));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (residue_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_res();
        return DATA_W'($urandom_range(0, int'(P - 1)));
    endfunction

    function automatic logic [63:0] rand_exp();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return 64'($signed($urandom_range(0, 40)) - 20);
            2: return {32'h0, $urandom};
            default: return {32'hffff_ffff, $urandom};
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            i_out_ready    <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // stalls come in bursts: extend a stall for a random length
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (rx_idle_en && rx_hold_cycles == 0 && $urandom_range(0, 15) == 0) begin
                burst = $urandom_range(1, 16);
                rx_hold_cycles = burst;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (residue_q.size() == 0) begin
                orphan_cnt++;
                if (mismatch_cnt + orphan_cnt <= 10)
                    $display("unexpected result %0d", o_result);
            end else begin
                logic [DATA_W-1:0] want;
                want = residue_q.pop_front();
                if (o_result !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt + orphan_cnt <= 10)
                        $display("result mismatch: expected %0d, got %0d", want, o_result);
                end
            end
        end
    end

    task automatic test_directed();
        send_req(OP_ADD, MOD_M1, MOD_M1, 64'd0);
        send_req(OP_ADD, '0, '0, 64'd0);
        send_req(OP_SUB, '0, MOD_M1, 64'd0);
        send_req(OP_SUB, MOD_M1, '0, 64'd0);
        send_req(OP_MUL, MOD_M1, MOD_M1, 64'd0);
        send_req(OP_MUL, '0, 30'd12345, 64'd0);
        send_req(OP_DIV, 30'd7, '0, 64'd0);
        send_req(OP_DIV, MOD_M1, MOD_M1, 64'd0);
        send_req(OP_DIV, 30'd123456, 30'd3, 64'd0);
        send_req(OP_POW, '0, '0, 64'd0);
        send_req(OP_POW, 30'd5, '0, 64'h7fff_ffff_ffff_ffff);
        send_req(OP_POW, 30'd3, '0, 64'h8000_0000_0000_0000);
        send_req(OP_POW, '0, '0, -64'sd1);
        send_req(OP_POW, 30'd2, '0, -64'sd1);
        send_req(OP_POW, MOD_M1, '0, 64'd2);
        send_req(OP_NEG, '0, '0, 64'd0);
        send_req(OP_NEG, MOD_M1, '0, 64'd0);
        // unreduced operands, including all-ones
        send_req(OP_ADD, 30'h3fff_ffff, 30'h3fff_ffff, 64'd0);
        send_req(OP_MUL, MODULUS, 30'h3fff_ffff, 64'd0);
        send_req(OP_DIV, 30'h3fff_ffff, MODULUS, 64'd0);
        send_req(OP_POW, 30'h3fff_ffff, MODULUS, -64'sd5);
        // undefined operation codes
        send_req(3'd6, 30'd1, 30'd2, 64'd3);
        send_req(3'd7, 30'h3fff_ffff, 30'h3fff_ffff, '1);
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        rx_hold_cycles = 3000;
        repeat (6) send_req(OP_ADD, rand_res(), rand_res(), 64'd0);
        wait_drained();
    endtask

    // sender pauses until drained between short bursts
    task automatic test_pause_drain();
        repeat (3) begin
            send_req(OP_MUL, rand_res(), rand_res(), 64'd0);
            send_req(OP_SUB, rand_res(), rand_res(), 64'd0);
            wait_drained();
        end
    endtask

    task automatic test_random(int n);
        logic [2:0] op;
        logic [DATA_W-1:0] a, b;
        for (int k = 0; k < n; k++) begin
            op = $urandom_range(0, 30) == 0 ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
            // mostly reduced values, some raw 30-bit ones
            a = ($urandom_range(0, 9) == 0) ? 30'($urandom) : rand_res();
            b = ($urandom_range(0, 9) == 0) ? 30'($urandom) : rand_res();
            if ($urandom_range(0, 19) == 0) b = '0;
            send_req(op, a, b, rand_exp());
        end
    endtask

    initial begin
        mismatch_cnt   = 0;
        orphan_cnt     = 0;
        rx_idle_en     = 1'b0;
        tx_idle_en     = 1'b0;
        rx_hold_cycles = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = '0;
        i_operand_a    = '0;
        i_operand_b    = '0;
        i_exponent     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        test_pause_drain();
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        test_random(1500);
        // final stretch with no idling on either side
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        wait (rx_hold_cycles == 0);
        test_random(360);

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (mismatch_cnt == 0 && orphan_cnt == 0 && residue_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog: fails the run if it does not finish in time
    initial begin
        #1s;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mau_pkg.sv
rtl/core/mau_reduce.sv
rtl/core/mau_mulmod.sv
rtl/core/modular_arithmetic_unit.sv
sim/tb_modular_arithmetic_unit.sv
